### design/min_tracking_stack_core_macros.svh
// ----------------------------------------------------------------------------
// min tracking stack assertion macros
// shared concurrent assertion helpers, clocked on clk_i, gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_CORE_MACROS_SVH
`define MIN_TRACKING_STACK_CORE_MACROS_SVH

// property must hold at every edge outside reset
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define MTS_ASSERT_NEVER(lbl, cond, msg) \
  `MTS_ASSERT(lbl, !(cond), msg)

`endif

### design/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// shared sizes, codes and controller/datapath link types of the min stack
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned MIN_ENTRY_W = VALUE_W + PTR_W;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 80;
  localparam int unsigned M_TUSER_W = 2;
  localparam int unsigned M_PAD_W   = M_TDATA_W - (2 * VALUE_W + PTR_W + 1);

  typedef enum logic [S_TUSER_W-1:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [M_TUSER_W-1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic exec;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic reload;
    logic out_free;
  } stat_t;

endpackage

### design/min_tracking_stack_core.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// signed 32-bit stack that reports its current minimum after every operation
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation per beat: tuser is the opcode (push / pop),
//   tdata the value to push. m_axis returns exactly one result beat per
//   operation: top, minimum, depth and empty flag in tdata, status in tuser.
// sequence:
//   accept, then result load; a pop that leaves values behind reloads in
//   between, since the new top and the uncovered minimum entry come back
//   through the registered read port of the spill memories. the next beat
//   is taken once the result is loaded.
// stall:
//   results sit in an output register; when m_axis is stalled one result
//   waits there while the next operation is already accepted and executed,
//   and further input waits until the register frees up.
// reset:
//   asynchronous, active low; the stack comes up empty and the output idle,
//   memory contents are not cleared (they are only read after being written)
// ----------------------------------------------------------------------------
module min_tracking_stack_core
  import mts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // operation input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] push_value
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [0] opcode
  // result output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [31:0] top_value, [63:32] min_value,
                                              // [72:64] entry_count, [73] is_empty
  output logic [M_TUSER_W-1:0] m_axis_tuser   // [1:0] status
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: one operation in flight at a time
  mts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // top-of-stack registers, spill memories and the result register
  mts_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

### design/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp
// stack datapath: top registers, spill memories, pointers and result register
// ----------------------------------------------------------------------------
`include "min_tracking_stack_core_macros.svh"

module mts_dp
  import mts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic [S_TUSER_W-1:0] s_tuser_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [M_TDATA_W-1:0] m_tdata_o,
  output logic [M_TUSER_W-1:0] m_tuser_o
);

  logic [VALUE_W-1:0] vmem [STACK_DEPTH];
  logic [MIN_ENTRY_W-1:0] mmem [STACK_DEPTH];

  logic [PTR_W-1:0]          vp_q, vp_d, mp_q, mp_d;
  logic signed [VALUE_W-1:0] top_q, top_d, mval_q, mval_d;
  logic [PTR_W-1:0]          mcnt_q, mcnt_d;
  logic                      drop_q, drop_d;
  status_e                   status_q, status_d;

  logic                   vwe, mwe;
  logic [ADDR_W-1:0]      vwaddr, mwaddr, vraddr, mraddr;
  logic [VALUE_W-1:0]     vrd_q;
  logic [MIN_ENTRY_W-1:0] mrd_q;

  logic                      is_push, empty, full, rd_en;
  logic signed [VALUE_W-1:0] push_val;

  logic                      m_tvalid_q;
  logic [M_TDATA_W-1:0]      m_tdata_q;
  logic [M_TUSER_W-1:0]      m_tuser_q;
  logic signed [VALUE_W-1:0] top_out, min_out;

  assign is_push  = (op_e'(s_tuser_i) == OP_PUSH);
  assign push_val = signed'(s_tdata_i[VALUE_W-1:0]);
  assign empty    = (vp_q == '0);
  assign full     = (vp_q == PTR_W'(STACK_DEPTH));
  assign rd_en    = cmd_i.exec && !is_push;

  assign vwaddr = vp_q[ADDR_W-1:0];
  assign mwaddr = ADDR_W'(mp_q - PTR_W'(1));
  assign vraddr = ADDR_W'(vp_q - PTR_W'(2));
  assign mraddr = ADDR_W'(mp_q - PTR_W'(2));

  // pop that leaves values behind; only looked at while an operation executes
  assign stat_o.reload   = !is_push && (vp_q >= PTR_W'(2));
  assign stat_o.out_free = !m_tvalid_q || m_tready_i;

  always_comb begin
    vp_d     = vp_q;
    mp_d     = mp_q;
    top_d    = top_q;
    mval_d   = mval_q;
    mcnt_d   = mcnt_q;
    drop_d   = drop_q;
    status_d = status_q;
    vwe      = 1'b0;
    mwe      = 1'b0;
    if (cmd_i.exec) begin
      drop_d = 1'b0;
      if (is_push) begin
        if (full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          status_d = ST_DONE;
          vwe      = 1'b1;
          top_d    = push_val;
          vp_d     = vp_q + PTR_W'(1);
          if (empty || mp_q == '0) begin
            mp_d   = PTR_W'(1);
            mval_d = push_val;
            mcnt_d = PTR_W'(1);
          end else if (push_val < mval_q) begin
            if (mp_q < PTR_W'(STACK_DEPTH)) begin
              // spill the covered minimum entry below the new one
              mwe    = 1'b1;
              mval_d = push_val;
              mcnt_d = PTR_W'(1);
              mp_d   = mp_q + PTR_W'(1);
            end
          end else if (push_val == mval_q) begin
            mcnt_d = mcnt_q + PTR_W'(1);
          end
        end
      end else begin
        if (empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          status_d = ST_DONE;
          vp_d     = vp_q - PTR_W'(1);
          if (mp_q != '0 && top_q == mval_q) begin
            if (mcnt_q <= PTR_W'(1)) begin
              mp_d   = mp_q - PTR_W'(1);
              drop_d = (mp_q >= PTR_W'(2));
            end else begin
              mcnt_d = mcnt_q - PTR_W'(1);
            end
          end
          if (vp_q == PTR_W'(1)) begin
            mp_d = '0;
          end
        end
      end
    end
    if (cmd_i.load) begin
      top_d = signed'(vrd_q);
      if (drop_q) begin
        {mcnt_d, mval_d} = mrd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[vwaddr] <= push_val;
    end
    if (rd_en) begin
      vrd_q <= vmem[vraddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mmem[mwaddr] <= {mcnt_q, mval_q};
    end
    if (rd_en) begin
      mrd_q <= mmem[mraddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q   <= '0;
      mp_q   <= '0;
      drop_q <= 1'b0;
    end else begin
      vp_q   <= vp_d;
      mp_q   <= mp_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    mval_q   <= mval_d;
    mcnt_q   <= mcnt_d;
    status_q <= status_d;
  end

  // result register
  assign top_out = empty ? '0 : top_q;
  assign min_out = (mp_q == '0) ? '0 : mval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_tdata_q <= {M_PAD_W'(0), empty, vp_q, min_out, top_out};
      m_tuser_q <= status_q;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  `MTS_ASSERT_NEVER(a_ptr_order, mp_q > vp_q, "more minimum entries than values")
  `MTS_ASSERT_NEVER(a_ptr_range, vp_q > PTR_W'(STACK_DEPTH), "value pointer past depth")
  `MTS_ASSERT_NEVER(a_empty_min, empty && mp_q != '0, "minimum entries on empty stack")
  `MTS_ASSERT_NEVER(a_live_count, mp_q != '0 && mcnt_q == '0, "live minimum with zero count")
  `MTS_ASSERT(a_load_cause, cmd_i.load |-> $past(stat_o.reload && cmd_i.exec), "stray reload")

endmodule

### design/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// sequencer: accept, optional top and minimum reload, result hand-off
// ----------------------------------------------------------------------------
module mts_ctrl
  import mts_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_tvalid_i,
  output logic  s_tready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.reload ? S_LOAD : S_RESP;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// min tracking stack testbench
// drives push and pop beats with random gaps and output stalls, predicts each
// result beat with a local stack model or a fixed expectation and checks it field by field
// ----------------------------------------------------------------------------
module testbench;
  import mts_pkg::*;

  localparam logic [VALUE_W-1:0] MAX_VAL = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] MIN_VAL = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] NEG_ONE = 32'hFFFF_FFFF;
  localparam logic [VALUE_W-1:0] NEG_TWO = 32'hFFFF_FFFE;

  // one result beat as seen on m_axis
  typedef struct packed {
    logic [VALUE_W-1:0] top_value;
    logic [VALUE_W-1:0] min_value;
    logic [PTR_W-1:0]   entry_count;
    logic               is_empty;
    status_e            status;
  } result_t;

  // one operation, with a fixed expectation where it is obvious
  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
    logic               has_want;
    result_t            want;
  } op_row_t;

  localparam result_t NONE = '0;

  // directed part: empty pops, extremes, repeated minima, drain to empty
  localparam op_row_t DIRECTED [0:25] = '{
    '{OP_POP,  '0,      1'b1, '{'0, '0, 9'd0, 1'b1, ST_POP_EMPTY}},
    '{OP_PUSH, 32'd5,   1'b1, '{32'd5, 32'd5, 9'd1, 1'b0, ST_DONE}},
    '{OP_PUSH, MAX_VAL, 1'b1, '{MAX_VAL, 32'd5, 9'd2, 1'b0, ST_DONE}},
    '{OP_PUSH, MIN_VAL, 1'b1, '{MIN_VAL, MIN_VAL, 9'd3, 1'b0, ST_DONE}},
    '{OP_PUSH, MIN_VAL, 1'b1, '{MIN_VAL, MIN_VAL, 9'd4, 1'b0, ST_DONE}},
    '{OP_PUSH, '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b1, '{'0, '0, 9'd0, 1'b1, ST_DONE}},
    '{OP_POP,  MAX_VAL, 1'b1, '{'0, '0, 9'd0, 1'b1, ST_POP_EMPTY}},
    '{OP_PUSH, NEG_ONE, 1'b0, NONE},
    '{OP_PUSH, NEG_ONE, 1'b0, NONE},
    '{OP_PUSH, 32'd3,   1'b0, NONE},
    '{OP_PUSH, NEG_TWO, 1'b0, NONE},
    '{OP_PUSH, NEG_TWO, 1'b0, NONE},
    '{OP_PUSH, NEG_ONE, 1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_PUSH, MIN_VAL, 1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE},
    '{OP_POP,  '0,      1'b0, NONE}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [31:0] push_value
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;  // [0] opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // [31:0] top, [63:32] min, [72:64] count, [73] empty
  logic [M_TUSER_W-1:0] m_axis_tuser;   // [1:0] status

  // local copy of the stack and of the minima stack
  logic [VALUE_W-1:0] held_vals  [STACK_DEPTH];
  logic [VALUE_W-1:0] min_vals   [STACK_DEPTH];
  int unsigned        min_reps   [STACK_DEPTH];
  int unsigned        held_depth = 0;
  int unsigned        min_depth  = 0;

  op_row_t     issued_q   [$];  // beats put on s_axis, not yet accepted
  result_t     results_q  [$];  // results still owed by the block
  int unsigned errors     = 0;
  int unsigned idle_pct   = 35;
  int unsigned gen_depth  = 0;  // stack depth as seen by the stimulus side

  min_tracking_stack_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // apply one operation to the local stack and report the stack afterwards
  function automatic result_t apply_stack_op(op_e op, logic [VALUE_W-1:0] v);
    result_t r;
    status_e st;
    st = ST_DONE;
    if (op == OP_PUSH) begin
      if (held_depth >= STACK_DEPTH) begin
        st = ST_PUSH_FULL;
      end else begin
        if (held_depth == 0 || min_depth == 0) begin
          min_vals[0] = v;
          min_reps[0] = 1;
          min_depth   = 1;
        end else if ($signed(v) < $signed(min_vals[min_depth-1])) begin
          if (min_depth < STACK_DEPTH) begin
            min_vals[min_depth] = v;
            min_reps[min_depth] = 1;
            min_depth++;
          end
        end else if (v == min_vals[min_depth-1]) begin
          min_reps[min_depth-1]++;
        end
        held_vals[held_depth] = v;
        held_depth++;
      end
    end else if (held_depth == 0) begin
      st = ST_POP_EMPTY;
    end else begin
      // popping the current minimum uses up one of its repeats
      if (min_depth > 0 && held_vals[held_depth-1] == min_vals[min_depth-1]) begin
        if (min_reps[min_depth-1] <= 1) min_depth--;
        else min_reps[min_depth-1]--;
      end
      held_depth--;
      if (held_depth == 0) min_depth = 0;
    end
    r.top_value   = (held_depth > 0) ? held_vals[held_depth-1] : '0;
    r.min_value   = (min_depth > 0) ? min_vals[min_depth-1] : '0;
    r.entry_count = held_depth[PTR_W-1:0];
    r.is_empty    = (held_depth == 0);
    r.status      = st;
    return r;
  endfunction

  task automatic check_result(input result_t want, input result_t got);
    if (got.top_value !== want.top_value) begin
      $display("%0t top_value: expected %h, got %h", $time, want.top_value, got.top_value);
      errors++;
    end
    if (got.min_value !== want.min_value) begin
      $display("%0t min_value: expected %h, got %h", $time, want.min_value, got.min_value);
      errors++;
    end
    if (got.entry_count !== want.entry_count) begin
      $display("%0t entry_count: expected %0d, got %0d", $time, want.entry_count,
               got.entry_count);
      errors++;
    end
    if (got.is_empty !== want.is_empty) begin
      $display("%0t is_empty: expected %b, got %b", $time, want.is_empty, got.is_empty);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t status: expected %0d, got %0d", $time, want.status, got.status);
      errors++;
    end
  endtask

  // result side first, then the input beat of the same edge
  always @(posedge clk_i) begin
    result_t got;
    op_row_t row;
    result_t pred;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.top_value   = m_axis_tdata[31:0];
        got.min_value   = m_axis_tdata[63:32];
        got.entry_count = m_axis_tdata[72:64];
        got.is_empty    = m_axis_tdata[73];
        got.status      = status_e'(m_axis_tuser);
        if (results_q.size() == 0) begin
          $display("%0t result beat with nothing expected: got %h / %h", $time,
                   m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          check_result(results_q.pop_front(), got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        row  = issued_q.pop_front();
        pred = apply_stack_op(row.op, row.value);
        // the predictor always runs so that its state stays in step
        results_q.push_back(row.has_want ? row.want : pred);
      end
    end
  end

  // result side stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return MIN_VAL;
      1:       return MAX_VAL;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 16) - 8;  // narrow range, many repeats
    endcase
  endfunction

  function automatic op_row_t make_row(op_e op, logic [VALUE_W-1:0] v);
    op_row_t row;
    row          = '0;
    row.op       = op;
    row.value    = v;
    row.has_want = 1'b0;
    return row;
  endfunction

  // present one beat after a random gap and hold it until accepted
  task automatic send_op(input op_row_t row);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.value;
    s_axis_tuser  <= row.op;
    issued_q.push_back(row);
    do @(posedge clk_i); while (!s_axis_tready);
    if (row.op == OP_PUSH && gen_depth < STACK_DEPTH) gen_depth++;
    else if (row.op == OP_POP && gen_depth > 0) gen_depth--;
  endtask

  // mixed pushes and pops around a shallow stack
  task automatic random_walk(input int unsigned beats);
    op_e op;
    repeat (beats) begin
      if (gen_depth == 0) op = ($urandom_range(0, 4) == 0) ? OP_POP : OP_PUSH;
      else op = ($urandom_range(0, 99) < 45) ? OP_POP : OP_PUSH;
      send_op(make_row(op, rand_value()));
    end
  endtask

  initial begin
    logic [VALUE_W-1:0] v;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_op(DIRECTED[i]);

    random_walk(30);

    // fill up as one long stretch with no gaps and no stalls:
    // descending pairs build a deep minima stack with repeats
    idle_pct = 0;
    while (gen_depth < STACK_DEPTH) begin
      v = ($urandom_range(0, 3) == 0) ? rand_value() : 32'd0 - (gen_depth >> 1);
      send_op(make_row(OP_PUSH, v));
    end
    idle_pct = 35;
    // pushes refused while full
    repeat (3) send_op(make_row(OP_PUSH, rand_value()));
    // drain with a few pushes mixed in, then pops refused on empty
    while (gen_depth > 0) begin
      if ($urandom_range(0, 19) == 0) send_op(make_row(OP_PUSH, rand_value()));
      else send_op(make_row(OP_POP, rand_value()));
    end
    repeat (2) send_op(make_row(OP_POP, rand_value()));

    s_axis_tvalid <= 1'b0;
    while (results_q.size() != 0 || issued_q.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected one
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
